### rtl/phf_pkg.sv
package phf_pkg;

    localparam int WINDOW     = 40;
    localparam int NUM_PAT    = 14;
    localparam int MOTIF_LEN  = 6;
    localparam int BASE_W     = 3;
    localparam int LEN_W      = 20;
    localparam int OFF_W      = 21;
    localparam int PAT_W      = 4;
    localparam int SEEN_W     = 7;
    localparam int DIST_W     = 6;
    localparam int WIN_W      = $clog2(WINDOW + 1);
    localparam int KEY_W      = MOTIF_LEN * BASE_W;
    localparam int REL_W      = 24;

    localparam logic [SEEN_W-1:0] SEEN_MAX = {SEEN_W{1'b1}};
    localparam logic [PAT_W-1:0]  PAT_NONE = PAT_W'(NUM_PAT);

    typedef logic [BASE_W-1:0] t_base;
    typedef logic [KEY_W-1:0]  t_key;

    localparam t_base BASE_A = 3'd0;
    localparam t_base BASE_C = 3'd1;
    localparam t_base BASE_G = 3'd2;
    localparam t_base BASE_T = 3'd3;

    // oldest base in the top bits
    localparam t_key PATTERN_TABLE [NUM_PAT] = '{
        {BASE_A, BASE_A, BASE_A, BASE_T, BASE_A, BASE_A},
        {BASE_A, BASE_A, BASE_A, BASE_T, BASE_T, BASE_A},
        {BASE_A, BASE_A, BASE_A, BASE_T, BASE_A, BASE_T},
        {BASE_A, BASE_A, BASE_A, BASE_T, BASE_G, BASE_A},
        {BASE_A, BASE_A, BASE_A, BASE_G, BASE_A, BASE_A},
        {BASE_A, BASE_T, BASE_A, BASE_T, BASE_A, BASE_A},
        {BASE_A, BASE_C, BASE_A, BASE_T, BASE_A, BASE_A},
        {BASE_A, BASE_A, BASE_A, BASE_T, BASE_A, BASE_C},
        {BASE_A, BASE_A, BASE_A, BASE_T, BASE_A, BASE_G},
        {BASE_A, BASE_A, BASE_G, BASE_T, BASE_A, BASE_A},
        {BASE_A, BASE_A, BASE_A, BASE_T, BASE_T, BASE_T},
        {BASE_A, BASE_A, BASE_A, BASE_T, BASE_C, BASE_A},
        {BASE_A, BASE_G, BASE_A, BASE_T, BASE_A, BASE_A},
        {BASE_C, BASE_A, BASE_A, BASE_T, BASE_A, BASE_A}
    };

    typedef struct packed {
        t_base             base;
        logic [WIN_W-1:0]  win;
        logic [LEN_W-1:0]  lm6;
        logic [REL_W-1:0]  vbase;
        logic              last;
    } t_item;

endpackage

### rtl/phf_in_stage.sv
module phf_in_stage (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [phf_pkg::BASE_W-1:0]   i_base,
    input  logic [phf_pkg::LEN_W-1:0]    i_transcript_length,
    input  logic [phf_pkg::LEN_W-1:0]    i_utr3_begin,
    input  logic signed [phf_pkg::OFF_W-1:0] i_variant_offset,
    input  logic                         i_last,
    input  logic                         i_adv,
    output logic                         o_item_valid,
    output phf_pkg::t_item               o_item
);
    import phf_pkg::*;

    logic              r_valid;
    t_item             r_item;
    t_item             n_item;
    logic [LEN_W:0]    span;
    logic              accept;

    assign o_ready = !r_valid || i_adv;
    assign accept  = i_valid && o_ready;

    always_comb begin
        span         = {1'b0, i_transcript_length} - {1'b0, i_utr3_begin};
        n_item.base  = i_base;
        n_item.last  = i_last;
        n_item.lm6   = i_transcript_length - LEN_W'(MOTIF_LEN);
        if (!span[LEN_W] && (span[LEN_W-1:0] < LEN_W'(WINDOW))) begin
            n_item.win = span[WIN_W-1:0];
        end else begin
            n_item.win = WIN_W'(WINDOW);
        end
        // mutation position minus (length - 6)
        n_item.vbase = {{(REL_W-LEN_W){1'b0}}, i_utr3_begin}
                     + {{(REL_W-OFF_W){i_variant_offset[OFF_W-1]}}, i_variant_offset}
                     - {{(REL_W-LEN_W){1'b0}}, i_transcript_length}
                     + REL_W'(MOTIF_LEN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

### rtl/phf_match.sv
module phf_match (
    input  phf_pkg::t_key               i_key,
    input  logic [phf_pkg::PAT_W-1:0]   i_limit,
    output logic                        o_hit,
    output logic [phf_pkg::PAT_W-1:0]   o_index
);
    import phf_pkg::*;

    always_comb begin
        o_hit   = 1'b0;
        o_index = PAT_NONE;
        for (int k = NUM_PAT - 1; k >= 0; k--) begin
            if ((PATTERN_TABLE[k] == i_key) && (PAT_W'(k) < i_limit)) begin
                o_hit   = 1'b1;
                o_index = PAT_W'(k);
            end
        end
    end

endmodule

### rtl/phf_track.sv
module phf_track (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_item_valid,
    input  phf_pkg::t_item              i_item,
    output logic                        o_adv,
    input  logic                        i_ready,
    output logic                        o_valid,
    output logic                        o_found,
    output logic [phf_pkg::LEN_W-1:0]   o_motif_start,
    output logic [phf_pkg::PAT_W-1:0]   o_pattern_number,
    output logic                        o_variant_in_motif
);
    import phf_pkg::*;

    t_key                r_key;
    logic [SEEN_W-1:0]   r_seen;
    logic [PAT_W-1:0]    r_best_pat;
    logic [DIST_W-1:0]   r_best_dist;
    logic                r_out_valid;
    logic                r_found;
    logic [LEN_W-1:0]    r_start;
    logic [PAT_W-1:0]    r_pat;
    logic                r_vim;

    t_key                n_key;
    logic [SEEN_W-1:0]   n_seen;
    logic [PAT_W-1:0]    n_best_pat;
    logic [DIST_W-1:0]   n_best_dist;
    logic                in_win;
    logic                hit;
    logic [PAT_W-1:0]    hit_index;
    logic                found;
    logic [REL_W-1:0]    diff;
    logic                out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_adv    = i_item_valid && (!i_item.last || out_free);

    assign n_key  = {r_key[KEY_W-BASE_W-1:0], i_item.base};
    assign n_seen = (r_seen == SEEN_MAX) ? SEEN_MAX : r_seen + 1'b1;
    assign in_win = (n_seen >= SEEN_W'(MOTIF_LEN)) && (n_seen <= SEEN_W'(i_item.win));

    phf_match u_match (
        .i_key   (n_key),
        .i_limit (r_best_pat),
        .o_hit   (hit),
        .o_index (hit_index)
    );

    always_comb begin
        n_best_pat  = r_best_pat;
        n_best_dist = r_best_dist;
        if (in_win && hit) begin
            n_best_pat  = hit_index;
            n_best_dist = DIST_W'(n_seen - SEEN_W'(MOTIF_LEN));
        end
        found = (n_best_pat != PAT_NONE);
        diff  = i_item.vbase + {{(REL_W-DIST_W){1'b0}}, n_best_dist};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key       <= '0;
            r_seen      <= '0;
            r_best_pat  <= PAT_NONE;
            r_best_dist <= '0;
        end else if (o_adv) begin
            if (i_item.last) begin
                r_key       <= '0;
                r_seen      <= '0;
                r_best_pat  <= PAT_NONE;
                r_best_dist <= '0;
            end else begin
                r_key       <= n_key;
                r_seen      <= n_seen;
                r_best_pat  <= n_best_pat;
                r_best_dist <= n_best_dist;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_adv && i_item.last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_item.last) begin
            r_found <= found;
            r_start <= found ? i_item.lm6 - LEN_W'(n_best_dist) : '0;
            r_pat   <= found ? n_best_pat : '0;
            r_vim   <= found && !diff[REL_W-1]
                    && (diff[REL_W-2:0] < (REL_W-1)'(MOTIF_LEN));
        end
    end

    assign o_valid            = r_out_valid;
    assign o_found            = r_found;
    assign o_motif_start      = r_start;
    assign o_pattern_number   = r_pat;
    assign o_variant_in_motif = r_vim;

endmodule

### rtl/polya_signal_hexamer_finder.sv
// Polyadenylation signal finder over a reversed base stream: takes one base per
// cycle, stalling only when a base carrying last meets an untaken result, and
// returns one result per request carrying last (input register, then the
// match-and-track step into the result register). The fourteen-hexamer priority
// match and best-hit update finish in that single step, which sets the rate of
// one base per cycle. Length, UTR start and offset are sampled with every base;
// hold them constant over a run. Bases with codes above three never match.
module polya_signal_hexamer_finder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [phf_pkg::BASE_W-1:0]       i_base,
    input  logic [phf_pkg::LEN_W-1:0]        i_transcript_length,
    input  logic [phf_pkg::LEN_W-1:0]        i_utr3_begin,
    input  logic signed [phf_pkg::OFF_W-1:0] i_variant_offset,
    input  logic                             i_last,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_found,
    output logic [phf_pkg::LEN_W-1:0]        o_motif_start,
    output logic [phf_pkg::PAT_W-1:0]        o_pattern_number,
    output logic                             o_variant_in_motif
);
    import phf_pkg::*;

    logic  item_valid;
    t_item item;
    logic  adv;

    phf_in_stage u_in_stage (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_base              (i_base),
        .i_transcript_length (i_transcript_length),
        .i_utr3_begin        (i_utr3_begin),
        .i_variant_offset    (i_variant_offset),
        .i_last              (i_last),
        .i_adv               (adv),
        .o_item_valid        (item_valid),
        .o_item              (item)
    );

    phf_track u_track (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_item_valid       (item_valid),
        .i_item             (item),
        .o_adv              (adv),
        .i_ready            (i_ready),
        .o_valid            (o_valid),
        .o_found            (o_found),
        .o_motif_start      (o_motif_start),
        .o_pattern_number   (o_pattern_number),
        .o_variant_in_motif (o_variant_in_motif)
    );

endmodule

### rtl/phf_checker.sv
module phf_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic                             o_ready,
    input  logic [phf_pkg::BASE_W-1:0]       i_base,
    input  logic [phf_pkg::LEN_W-1:0]        i_transcript_length,
    input  logic [phf_pkg::LEN_W-1:0]        i_utr3_begin,
    input  logic signed [phf_pkg::OFF_W-1:0] i_variant_offset,
    input  logic                             i_last,
    input  logic                             o_valid,
    input  logic                             i_ready,
    input  logic                             o_found,
    input  logic [phf_pkg::LEN_W-1:0]        o_motif_start,
    input  logic [phf_pkg::PAT_W-1:0]        o_pattern_number,
    input  logic                             o_variant_in_motif
);
    import phf_pkg::*;

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_motif_start == '0) && (o_pattern_number == '0)
                                  && !o_variant_in_motif)
        else $error("empty result carries nonzero fields");

    a_pat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (o_pattern_number < PAT_NONE))
        else $error("pattern number out of range");

    a_vim_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_variant_in_motif) |-> o_found)
        else $error("variant in motif without a hit");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid && $stable(o_found)
                                  && $stable(o_motif_start) && $stable(o_pattern_number))
        else $error("stalled result changed");

endmodule

bind polya_signal_hexamer_finder phf_checker u_phf_checker (.*);

### verif/polya_signal_hexamer_finder_test.sv
`timescale 1ns / 100ps

module polya_signal_hexamer_finder_test;
    import phf_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;

    // reversed spelling, oldest base in the top bits
    localparam logic [KEY_W-1:0] HEXAMERS [NUM_PAT] = '{
        {BASE_A, BASE_A, BASE_A, BASE_T, BASE_A, BASE_A},
        {BASE_A, BASE_A, BASE_A, BASE_T, BASE_T, BASE_A},
        {BASE_A, BASE_A, BASE_A, BASE_T, BASE_A, BASE_T},
        {BASE_A, BASE_A, BASE_A, BASE_T, BASE_G, BASE_A},
        {BASE_A, BASE_A, BASE_A, BASE_G, BASE_A, BASE_A},
        {BASE_A, BASE_T, BASE_A, BASE_T, BASE_A, BASE_A},
        {BASE_A, BASE_C, BASE_A, BASE_T, BASE_A, BASE_A},
        {BASE_A, BASE_A, BASE_A, BASE_T, BASE_A, BASE_C},
        {BASE_A, BASE_A, BASE_A, BASE_T, BASE_A, BASE_G},
        {BASE_A, BASE_A, BASE_G, BASE_T, BASE_A, BASE_A},
        {BASE_A, BASE_A, BASE_A, BASE_T, BASE_T, BASE_T},
        {BASE_A, BASE_A, BASE_A, BASE_T, BASE_C, BASE_A},
        {BASE_A, BASE_G, BASE_A, BASE_T, BASE_A, BASE_A},
        {BASE_C, BASE_A, BASE_A, BASE_T, BASE_A, BASE_A}
    };

    typedef struct {
        logic              found;
        logic [LEN_W-1:0]  motif_start;
        logic [PAT_W-1:0]  pattern;
        logic              variant_in_motif;
    } t_motif_hit;

    class t_hexamer_tracker;
        t_base             recent [MOTIF_LEN];
        logic [SEEN_W-1:0] seen;
        int                best_pat;
        logic [DIST_W-1:0] best_dist;
        t_motif_hit        pending_hits [$];
        int                mismatches;

        function new();
            clear();
            mismatches = 0;
        endfunction

        function void clear();
            foreach (recent[i]) recent[i] = BASE_A;
            seen      = '0;
            best_pat  = NUM_PAT;
            best_dist = '0;
        endfunction

        function void note_base(t_base b, logic [LEN_W-1:0] len, logic [LEN_W-1:0] ubeg,
                                logic signed [OFF_W-1:0] voff, logic last);
            int unsigned win;
            int          k;
            longint      motif_pos;
            longint      diff;
            t_key        key;
            t_motif_hit  hit;
            for (k = 0; k < MOTIF_LEN - 1; k++) recent[k] = recent[k + 1];
            recent[MOTIF_LEN - 1] = b;
            if (seen != SEEN_MAX) seen++;
            win = WINDOW;
            if (ubeg <= len && (32'(len) - 32'(ubeg)) < win) win = 32'(len) - 32'(ubeg);
            if (seen >= MOTIF_LEN && 32'(seen) <= win) begin
                key = {recent[0], recent[1], recent[2], recent[3], recent[4], recent[5]};
                for (k = 0; k < NUM_PAT && k < best_pat; k++) begin
                    if (key == HEXAMERS[k]) begin
                        best_pat  = k;
                        best_dist = DIST_W'(seen - MOTIF_LEN);
                        break;
                    end
                end
            end
            if (!last) return;
            hit = '{found: 1'b0, motif_start: '0, pattern: '0, variant_in_motif: 1'b0};
            if (best_pat < NUM_PAT) begin
                motif_pos = longint'(len) - MOTIF_LEN - longint'(best_dist);
                diff = longint'(voff) + longint'(ubeg) - motif_pos;
                hit.found            = 1'b1;
                hit.motif_start      = motif_pos[LEN_W-1:0];
                hit.pattern          = PAT_W'(best_pat);
                hit.variant_in_motif = (diff >= 0 && diff < MOTIF_LEN);
            end
            pending_hits.push_back(hit);
            clear();
        endfunction

        function void check_hit(logic found, logic [LEN_W-1:0] start, logic [PAT_W-1:0] pat,
                                logic in_motif);
            t_motif_hit want;
            if (pending_hits.size() == 0) begin
                $error("unexpected result: found %0d motif_start %0d pattern_number %0d",
                       found, start, pat);
                mismatches++;
                return;
            end
            want = pending_hits.pop_front();
            if (found !== want.found) begin
                $error("found: expected %0d, got %0d", want.found, found);
                mismatches++;
            end
            if (start !== want.motif_start) begin
                $error("motif_start: expected %0d, got %0d", want.motif_start, start);
                mismatches++;
            end
            if (pat !== want.pattern) begin
                $error("pattern_number: expected %0d, got %0d", want.pattern, pat);
                mismatches++;
            end
            if (in_motif !== want.variant_in_motif) begin
                $error("variant_in_motif: expected %0d, got %0d",
                       want.variant_in_motif, in_motif);
                mismatches++;
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic [BASE_W-1:0]       i_base;
    logic [LEN_W-1:0]        i_transcript_length;
    logic [LEN_W-1:0]        i_utr3_begin;
    logic signed [OFF_W-1:0] i_variant_offset;
    logic                    i_last;
    logic                    o_valid;
    logic                    i_ready;
    logic                    o_found;
    logic [LEN_W-1:0]        o_motif_start;
    logic [PAT_W-1:0]        o_pattern_number;
    logic                    o_variant_in_motif;

    t_hexamer_tracker tracker;
    int             tx_idle_pct = 0;
    int             rx_idle_pct = 0;
    int             bases_sent  = 0;
    bit             want_stall  = 1'b0;
    bit             stall_done  = 1'b0;

    polya_signal_hexamer_finder dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_base              (i_base),
        .i_transcript_length (i_transcript_length),
        .i_utr3_begin        (i_utr3_begin),
        .i_variant_offset    (i_variant_offset),
        .i_last              (i_last),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_found             (o_found),
        .o_motif_start       (o_motif_start),
        .o_pattern_number    (o_pattern_number),
        .o_variant_in_motif  (o_variant_in_motif)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready)
            tracker.note_base(i_base, i_transcript_length, i_utr3_begin, i_variant_offset,
                              i_last);
        if (i_rst_n && o_valid && i_ready)
            tracker.check_hit(o_found, o_motif_start, o_pattern_number, o_variant_in_motif);
    end

    initial begin : result_sink
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (want_stall && !stall_done) begin
                i_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                stall_done = 1'b1;
            end else begin
                i_ready = ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet = 0;
            else quiet++;
        end
        $display("polya_signal_hexamer_finder_test: errors");
        $finish;
    end

    task automatic send_base(input t_base b, input logic [LEN_W-1:0] len,
                             input logic [LEN_W-1:0] ubeg, input int voff, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid             = 1'b1;
        i_base              = b;
        i_transcript_length = len;
        i_utr3_begin        = ubeg;
        i_variant_offset    = OFF_W'(voff);
        i_last              = last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        bases_sent++;
    endtask

    task automatic send_transcript(input t_base seq [$], input logic [LEN_W-1:0] len,
                                   input logic [LEN_W-1:0] ubeg, input int voff);
        foreach (seq[i]) send_base(seq[i], len, ubeg, voff, i == seq.size() - 1);
    endtask

    task automatic random_transcript();
        t_base            seq [$];
        int               n;
        int               sel;
        int               k;
        int               p;
        int               j;
        int               plants;
        int               voff;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] ubeg;
        sel = $urandom_range(99);
        if (sel < 5) n = $urandom_range(140, 100);
        else if (sel < 15) n = $urandom_range(8, 1);
        else n = $urandom_range(50, 6);
        if ($urandom_range(3) == 0) len = LEN_W'($urandom);
        else len = LEN_W'($urandom_range(400));
        sel = $urandom_range(9);
        if (sel == 0) ubeg = LEN_W'($urandom);
        else if (sel == 1) ubeg = len + LEN_W'($urandom_range(50, 1));
        else ubeg = len - LEN_W'($urandom_range((len < 60) ? len : 60));
        if ($urandom_range(1) == 0) begin
            voff = int'($urandom_range(2097150)) - 1048575;
        end else begin
            voff = int'(len) - int'(ubeg) - int'($urandom_range(50));
            if (voff > 1048575) voff = 1048575;
            if (voff < -1048575) voff = -1048575;
        end
        for (j = 0; j < n; j++)
            seq.push_back(($urandom_range(99) < 55) ? BASE_A : t_base'($urandom_range(7)));
        plants = (n >= MOTIF_LEN && $urandom_range(4) != 0) ? $urandom_range(2, 1) : 0;
        repeat (plants) begin
            k = $urandom_range(NUM_PAT - 1);
            p = $urandom_range(n - MOTIF_LEN);
            for (j = 0; j < MOTIF_LEN; j++) seq[p + j] = HEXAMERS[k][KEY_W - 1 - 3 * j -: 3];
            // break the hexamer now and then
            if ($urandom_range(4) == 0)
                seq[p + $urandom_range(MOTIF_LEN - 1)] = t_base'($urandom_range(7));
        end
        send_transcript(seq, len, ubeg, voff);
    endtask

    initial begin : stimulus
        t_base seq [$];
        tracker             = new();
        i_rst_n             = 1'b0;
        i_valid             = 1'b0;
        i_base              = '0;
        i_transcript_length = '0;
        i_utr3_begin        = '0;
        i_variant_offset    = '0;
        i_last              = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        tx_idle_pct = 32;
        rx_idle_pct = 55;
        seq = '{3'd7};
        send_transcript(seq, '0, '0, 0);
        seq = '{BASE_A, BASE_A, BASE_A, BASE_T, BASE_A, BASE_A};
        send_transcript(seq, 20'd105, 20'd100, 0);
        send_transcript(seq, 20'd3, 20'hFFFFF, -1048575);
        seq = '{BASE_C, BASE_A, BASE_A, BASE_T, BASE_A, BASE_A,
                BASE_A, BASE_A, BASE_A, BASE_T, BASE_A, BASE_A};
        send_transcript(seq, 20'hFFFFF, '0, 1048575);

        while (bases_sent < 310) random_transcript();
        tx_idle_pct = 55;
        rx_idle_pct = 32;
        while (bases_sent < 620) random_transcript();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        want_stall  = 1'b1;
        while (bases_sent < 950) random_transcript();
        i_valid = 1'b0;

        while (tracker.pending_hits.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending_hits.size() == 0)
            $display("polya_signal_hexamer_finder_test: clean");
        else
            $display("polya_signal_hexamer_finder_test: errors");
        $finish;
    end

endmodule

### filelist.f
rtl/phf_pkg.sv
rtl/phf_in_stage.sv
rtl/phf_match.sv
rtl/phf_track.sv
rtl/polya_signal_hexamer_finder.sv
rtl/phf_checker.sv
verif/polya_signal_hexamer_finder_test.sv
